// ===== rtl/core/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor sequencer package
// Shared phase type, event codes, command bytes and the result bundle.
// ----------------------------------------------------------------------------
package hss_pkg;

  typedef enum logic [2:0] {
    PH_RST     = 3'd0,
    PH_CAL     = 3'd1,
    PH_CAL_STA = 3'd2,
    PH_TRG     = 3'd3,
    PH_TRG_STA = 3'd4,
    PH_READ    = 3'd5,
    PH_IDLE    = 3'd6,
    PH_ERR     = 3'd7
  } phase_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_NO_ACK = 2'd1;
  localparam logic [1:0] ERR_CAL    = 2'd2;

  localparam logic [7:0] CMD_SOFT_RST = 8'hBA;
  localparam logic [7:0] CMD_CAL      = 8'hE1;
  localparam logic [7:0] CMD_CAL_ARG  = 8'h08;
  localparam logic [7:0] CMD_TRG      = 8'hAC;
  localparam logic [7:0] CMD_TRG_ARG  = 8'h33;

  localparam int STS_BUSY_BIT = 7;
  localparam int STS_CAL_BIT  = 3;

  localparam logic [9:0] SCALE = 10'd625;

  localparam int HUM_W  = 14;
  localparam int TEMP_W = 15;
  localparam int RAW_W  = 20;

  typedef struct packed {
    logic       issue_transfer;
    logic [1:0] wr_len;
    logic [2:0] rd_len;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
    logic [7:0] cmd_third;
    logic       new_data;
    logic [1:0] error_code;
    phase_t     phase;
  } ctrl_res_t;

endpackage

// ===== rtl/core/hss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor sequencer control
// Phase and error registers with the next-phase and transfer selection.
// ----------------------------------------------------------------------------
module hss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [1:0]        op,
  input  logic              success,
  input  logic [7:0]        status_byte,
  output logic              load_results,
  output hss_pkg::ctrl_res_t res
);

  hss_pkg::phase_t phase, phase_next;
  logic [1:0]      error, error_next;
  logic            act;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hss_pkg::PH_ERR;
      error <= hss_pkg::ERR_NONE;
    end else if (advance) begin
      phase <= phase_next;
      error <= error_next;
    end
  end

  always_comb begin
    phase_next   = phase;
    error_next   = error;
    act          = 1'b0;
    load_results = 1'b0;
    case (op)
      hss_pkg::OP_START: begin
        error_next = hss_pkg::ERR_NONE;
        phase_next = hss_pkg::PH_RST;
        act        = 1'b1;
      end
      hss_pkg::OP_READ: begin
        if (phase == hss_pkg::PH_IDLE) begin
          phase_next = hss_pkg::PH_TRG;
          act        = 1'b1;
        end
      end
      hss_pkg::OP_DONE: begin
        if (!success) begin
          error_next = hss_pkg::ERR_NO_ACK;
          phase_next = hss_pkg::PH_ERR;
        end else begin
          case (phase)
            hss_pkg::PH_RST: begin
              phase_next = hss_pkg::PH_CAL;
              act        = 1'b1;
            end
            hss_pkg::PH_CAL: begin
              phase_next = hss_pkg::PH_CAL_STA;
              act        = 1'b1;
            end
            hss_pkg::PH_CAL_STA: begin
              if (status_byte[hss_pkg::STS_BUSY_BIT]) begin
                phase_next = hss_pkg::PH_CAL_STA;
                act        = 1'b1;
              end else if (status_byte[hss_pkg::STS_CAL_BIT]) begin
                phase_next = hss_pkg::PH_TRG;
                act        = 1'b1;
              end else begin
                error_next = hss_pkg::ERR_CAL;
                phase_next = hss_pkg::PH_ERR;
              end
            end
            hss_pkg::PH_TRG: begin
              phase_next = hss_pkg::PH_TRG_STA;
              act        = 1'b1;
            end
            hss_pkg::PH_TRG_STA: begin
              phase_next = status_byte[hss_pkg::STS_BUSY_BIT] ?
                           hss_pkg::PH_TRG_STA : hss_pkg::PH_READ;
              act        = 1'b1;
            end
            hss_pkg::PH_READ: begin
              phase_next   = hss_pkg::PH_IDLE;
              load_results = 1'b1;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    res                = '0;
    res.new_data       = (op == hss_pkg::OP_DONE) && (phase_next == hss_pkg::PH_IDLE);
    res.error_code     = error_next;
    res.phase          = phase_next;
    if (act) begin
      case (phase_next)
        hss_pkg::PH_RST: begin
          res.issue_transfer = 1'b1;
          res.wr_len         = 2'd1;
          res.cmd_first      = hss_pkg::CMD_SOFT_RST;
        end
        hss_pkg::PH_CAL: begin
          res.issue_transfer = 1'b1;
          res.wr_len         = 2'd3;
          res.cmd_first      = hss_pkg::CMD_CAL;
          res.cmd_second     = hss_pkg::CMD_CAL_ARG;
        end
        hss_pkg::PH_CAL_STA, hss_pkg::PH_TRG_STA: begin
          res.issue_transfer = 1'b1;
          res.rd_len         = 3'd1;
        end
        hss_pkg::PH_TRG: begin
          res.issue_transfer = 1'b1;
          res.wr_len         = 2'd3;
          res.cmd_first      = hss_pkg::CMD_TRG;
          res.cmd_second     = hss_pkg::CMD_TRG_ARG;
        end
        hss_pkg::PH_READ: begin
          res.issue_transfer = 1'b1;
          res.rd_len         = 3'd6;
        end
        default: begin
          res.issue_transfer = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/hss_conv.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor sequencer conversion
// Scales the raw 20-bit readings and holds the stored results.
// ----------------------------------------------------------------------------
module hss_conv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [7:0]                 data_byte1,
  input  logic [7:0]                 data_byte2,
  input  logic [7:0]                 data_byte3,
  input  logic [7:0]                 data_byte4,
  input  logic [7:0]                 data_byte5,
  output logic [hss_pkg::HUM_W-1:0]  humidity,
  output logic [hss_pkg::TEMP_W-1:0] temperature
);

  logic [hss_pkg::RAW_W-1:0]    raw_hum, raw_temp;
  logic [hss_pkg::RAW_W+9:0]    prod_hum, prod_temp;
  logic [hss_pkg::HUM_W-1:0]    hum_calc, hum_stored;
  logic [hss_pkg::TEMP_W-1:0]   temp_calc, temp_stored;

  assign raw_hum   = {data_byte1, data_byte2, data_byte3[7:4]};
  assign raw_temp  = {data_byte3[3:0], data_byte4, data_byte5};
  assign prod_hum  = raw_hum * hss_pkg::SCALE;
  assign prod_temp = raw_temp * hss_pkg::SCALE;
  assign hum_calc  = prod_hum[16 +: hss_pkg::HUM_W];
  assign temp_calc = prod_temp[15 +: hss_pkg::TEMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      hum_stored  <= '0;
      temp_stored <= '0;
    end else if (load) begin
      hum_stored  <= hum_calc;
      temp_stored <= temp_calc;
    end
  end

  assign humidity    = load ? hum_calc : hum_stored;
  assign temperature = load ? temp_calc : temp_stored;

endmodule

// ===== rtl/core/humidity_sensor_sequencer.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor sequencer
// Steps a humidity/temperature sensor through reset, calibration, trigger,
// status polling and data read, one event item to one result item.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: op[1:0]; tdata: success, status_byte, data_byte1..5
// m_*      out  tdata: issue_transfer, wr_len, rd_len, cmd_first,
//               cmd_second, cmd_third, new_data, error_code, humidity,
//               temperature, phase
//
// An item is held in the input register and leaves through the output
// register; one item is taken per cycle while the output is not stalled.
// The phase and error registers update when an item moves from the input
// register to the output register. A stalled output holds the result and,
// once the input register is full, stalls the input. Reset puts the phase
// in error until a start item arrives.
// ----------------------------------------------------------------------------
module humidity_sensor_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // success, status_byte, data_byte1..5, zero pad
  input  logic [1:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // issue_transfer, wr_len, rd_len,
                                // cmd_first, cmd_second, cmd_third, new_data,
                                // error_code, humidity, temperature, phase, pad
);

  logic                       in_vld;
  logic [1:0]                 in_op;
  logic [48:0]                in_data;
  logic                       advance;
  logic                       load_results;
  hss_pkg::ctrl_res_t         res;
  logic [hss_pkg::HUM_W-1:0]  humidity;
  logic [hss_pkg::TEMP_W-1:0] temperature;
  logic                       out_vld;
  logic [64:0]                out_data;

  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_data <= s_tdata[48:0];
    end
  end

  hss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .op           (in_op),
    .success      (in_data[0]),
    .status_byte  (in_data[8:1]),
    .load_results (load_results),
    .res          (res)
  );

  hss_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && load_results),
    .data_byte1  (in_data[16:9]),
    .data_byte2  (in_data[24:17]),
    .data_byte3  (in_data[32:25]),
    .data_byte4  (in_data[40:33]),
    .data_byte5  (in_data[48:41]),
    .humidity    (humidity),
    .temperature (temperature)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {res.phase, temperature, humidity, res.error_code, res.new_data,
                   res.cmd_third, res.cmd_second, res.cmd_first, res.rd_len,
                   res.wr_len, res.issue_transfer};
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'd0, out_data};

endmodule

// ===== rtl/core/hss_checker.sv =====
// ----------------------------------------------------------------------------
// Humidity sensor sequencer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A stalled result item keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // With no transfer to start, counts and command bytes are zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[29:1] == 29'd0)
    else $error("transfer fields set without a transfer");

  // New data is only reported in the idle phase.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30] |-> m_tdata[64:62] == hss_pkg::PH_IDLE)
    else $error("new data outside idle");

  // A nonzero error code is only seen in the error phase.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32:31] != hss_pkg::ERR_NONE |->
    m_tdata[64:62] == hss_pkg::PH_ERR)
    else $error("error code outside the error phase");

endmodule

bind humidity_sensor_sequencer hss_checker u_hss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
